// ===== src/lcrd_pkg.sv =====
// Shared types, constants and register codes for the lat-long camera ray block.
// Depends on nothing; every other file of the block imports it.
package lcrd_pkg;

    // Fixed field widths of the item channels.
    localparam int COORD_BITS = 20;
    localparam int DIR_BITS   = 16;
    localparam int TIME_BITS  = 17;

    // Default angle resolution in bits of a turn.
    localparam int ANGLE_BITS_DEF = 16;

    // Latency of the sine/cosine pipeline in cycles.
    localparam int SC_LAT = 15;

    // Number of Horner steps of the cosine chain; the sine chain has one less.
    localparam int NSTEP = 5;

    // Fixed-point constants.
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

    // Exact reciprocals for division by small constants: m = ceil(2^(32+l)/d).
    localparam logic [32:0] RCP_72 = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
    localparam logic [32:0] RCP_42 = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
    localparam logic [32:0] RCP_20 = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
    localparam logic [32:0] RCP_6  = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
    localparam logic [32:0] RCP_90 = 33'(((64'd1 << 39) + 64'd89) / 64'd90);
    localparam logic [32:0] RCP_56 = 33'(((64'd1 << 38) + 64'd55) / 64'd56);
    localparam logic [32:0] RCP_30 = 33'(((64'd1 << 37) + 64'd29) / 64'd30);
    localparam logic [32:0] RCP_12 = 33'(((64'd1 << 36) + 64'd11) / 64'd12);
    localparam logic [32:0] RCP_2  = 33'(((64'd1 << 33) + 64'd1) / 64'd2);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_X_SCALE    = 3'd0,
        REG_Y_SCALE    = 3'd1,
        REG_ROW_X      = 3'd2,
        REG_ROW_Y      = 3'd3,
        REG_ROW_Z      = 3'd4,
        REG_SHUT_OPEN  = 3'd5,
        REG_SHUT_CLOSE = 3'd6
    } lcrd_reg_t;

    // Input item.
    typedef struct packed {
        logic [COORD_BITS-1:0] image_x;
        logic [COORD_BITS-1:0] image_y;
        logic [TIME_BITS-1:0]  sample_time;
    } lcrd_in_t;

    // Result item.
    typedef struct packed {
        logic signed [DIR_BITS-1:0] dir_x;
        logic signed [DIR_BITS-1:0] dir_y;
        logic signed [DIR_BITS-1:0] dir_z;
        logic signed [31:0]         ray_time;
    } lcrd_out_t;

    // Context carried along the Horner chains.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] x2;
        logic [1:0]  quad;
        logic        swap;
    } lcrd_ctx_t;

    // Sine chain steps 1..4 divide by 72, 42, 20 and 6.
    function automatic logic [32:0] sin_rcp(input int k);
        logic [32:0] r;
        case (k)
            1: r = RCP_72;
            2: r = RCP_42;
            3: r = RCP_20;
            default: r = RCP_6;
        endcase
        return r;
    endfunction

    function automatic int sin_shift(input int k);
        int s;
        case (k)
            1: s = 39;
            2: s = 38;
            3: s = 37;
            default: s = 35;
        endcase
        return s;
    endfunction

    // Cosine chain steps 0..4 divide by 90, 56, 30, 12 and 2.
    function automatic logic [32:0] cos_rcp(input int k);
        logic [32:0] r;
        case (k)
            0: r = RCP_90;
            1: r = RCP_56;
            2: r = RCP_30;
            3: r = RCP_12;
            default: r = RCP_2;
        endcase
        return r;
    endfunction

    function automatic int cos_shift(input int k);
        int s;
        case (k)
            0: s = 39;
            1: s = 38;
            2: s = 37;
            3: s = 36;
            default: s = 33;
        endcase
        return s;
    endfunction

endpackage

// ===== src/latlong_camera_ray_direction_top.sv =====
// Lat-long camera ray direction generator: top level with registers and pipeline.
// Depends on lcrd_pkg and lcrd_sincos.
//
// One image sample enters per clock and yields one world-space ray direction and
// ray time; sustained throughput is one item per cycle while m_ready is high.
// The pipeline runs from input acceptance to a valid result through the angle
// multiply, the two sine/cosine units in parallel (15 stages each: quadrant split,
// radian scaling, squaring, ten stages of Horner evaluation at two stages per
// polynomial term, then swap and quadrant signs) and the three-stage direction
// and matrix rotation.
// The whole pipeline holds while a result waits, so s_ready drops only while a result waits and m_ready is low.
// Configuration registers sit at 8-byte spacing on the APB port and are meant to
// be written only while the block is idle.
module latlong_camera_ray_direction_top
    import lcrd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lcrd_in_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output lcrd_out_t   m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int NSTAGE = SC_LAT + 4;
    localparam int RSH    = 46 - DIR_BITS;
    localparam int PXW    = COORD_BITS + 32;

    // Configuration registers.
    logic [31:0] x_scale_reg;
    logic [31:0] y_scale_reg;
    logic [47:0] row_x_reg;
    logic [47:0] row_y_reg;
    logic [47:0] row_z_reg;
    logic [31:0] shut_open_reg;
    logic [31:0] shut_close_reg;
    logic        cfg_wr;
    lcrd_reg_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = lcrd_reg_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_scale_reg    <= 32'd1048576;
            y_scale_reg    <= 32'd2097152;
            row_x_reg      <= 48'd16384;
            row_y_reg      <= 48'd1073741824;
            row_z_reg      <= 48'd70368744177664;
            shut_open_reg  <= 32'd0;
            shut_close_reg <= 32'd65536;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_X_SCALE:    x_scale_reg    <= pwdata[31:0];
                REG_Y_SCALE:    y_scale_reg    <= pwdata[31:0];
                REG_ROW_X:      row_x_reg      <= pwdata[47:0];
                REG_ROW_Y:      row_y_reg      <= pwdata[47:0];
                REG_ROW_Z:      row_z_reg      <= pwdata[47:0];
                REG_SHUT_OPEN:  shut_open_reg  <= pwdata[31:0];
                REG_SHUT_CLOSE: shut_close_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (cfg_idx)
            REG_X_SCALE:    prdata = {32'd0, x_scale_reg};
            REG_Y_SCALE:    prdata = {32'd0, y_scale_reg};
            REG_ROW_X:      prdata = {16'd0, row_x_reg};
            REG_ROW_Y:      prdata = {16'd0, row_y_reg};
            REG_ROW_Z:      prdata = {16'd0, row_z_reg};
            REG_SHUT_OPEN:  prdata = {32'd0, shut_open_reg};
            REG_SHUT_CLOSE: prdata = {32'd0, shut_close_reg};
            default:        prdata = 64'd0;
        endcase
    end

    // Pipeline advance and valid bits that travel with the data.
    logic              ce;
    logic [NSTAGE:1]   valid_reg;

    assign ce      = !valid_reg[NSTAGE] || m_ready;
    assign s_ready = ce;
    assign m_valid = valid_reg[NSTAGE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[NSTAGE-1:1], s_valid};
        end
    end

    // Stage 1: turn products and shutter product.
    logic [PXW-1:0]     prod_x_reg;
    logic [PXW-1:0]     prod_y_reg;
    logic signed [32:0] t_diff;
    logic signed [50:0] tprod_reg;

    assign t_diff = 33'($signed(shut_close_reg)) - 33'($signed(shut_open_reg));

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_x_reg <= PXW'(s_item.image_x) * PXW'(x_scale_reg);
            prod_y_reg <= PXW'(s_item.image_y) * PXW'(y_scale_reg);
            tprod_reg  <= 51'(t_diff) * 51'($signed({1'b0, s_item.sample_time}));
        end
    end

    // Stage 2: rounded, saturated ray time, then delayed to the output.
    logic signed [50:0] t_rnd;
    logic signed [51:0] t_sum;
    logic signed [31:0] t_sat;
    logic signed [31:0] time_pipe_reg [2:NSTAGE-1];

    assign t_rnd = (tprod_reg + 51'sd32768) >>> 16;
    assign t_sum = 52'(t_rnd) + 52'($signed(shut_open_reg));

    always_comb begin
        if (t_sum > 52'sd2147483647) begin
            t_sat = 32'sh7FFF_FFFF;
        end else if (t_sum < -52'sd2147483648) begin
            t_sat = 32'sh8000_0000;
        end else begin
            t_sat = t_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            time_pipe_reg[2] <= t_sat;
            for (int i = 3; i < NSTAGE; i++) begin
                time_pipe_reg[i] <= time_pipe_reg[i-1];
            end
        end
    end

    // Stages 2 to 16: sine and cosine of both angles.
    logic signed [31:0] sin_th;
    logic signed [31:0] cos_th;
    logic signed [31:0] sin_ph;
    logic signed [31:0] cos_ph;

    lcrd_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_theta (
        .aclk    (aclk),
        .ce      (ce),
        .angle   (prod_y_reg[40 -: ANGLE_BITS]),
        .sin_q30 (sin_th),
        .cos_q30 (cos_th)
    );

    lcrd_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_phi (
        .aclk    (aclk),
        .ce      (ce),
        .angle   (prod_x_reg[39 -: ANGLE_BITS]),
        .sin_q30 (sin_ph),
        .cos_q30 (cos_ph)
    );

    // Stage 17: camera-space unit direction, floored to Q.30.
    logic signed [63:0] dx_prod;
    logic signed [63:0] dz_prod;
    logic signed [31:0] dx_reg;
    logic signed [31:0] dy_reg;
    logic signed [31:0] dz_reg;

    assign dx_prod = 64'(sin_th) * 64'(cos_ph);
    assign dz_prod = 64'(sin_th) * 64'(sin_ph);

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg <= dx_prod[61:30];
            dy_reg <= cos_th;
            dz_reg <= dz_prod[61:30];
        end
    end

    // Stage 18: the nine matrix products.
    logic signed [47:0] mp_reg [3][3];
    logic [47:0]        rows [3];

    assign rows[0] = row_x_reg;
    assign rows[1] = row_y_reg;
    assign rows[2] = row_z_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                mp_reg[r][0] <= 48'($signed(rows[r][15:0])) * 48'(dx_reg);
                mp_reg[r][1] <= 48'($signed(rows[r][31:16])) * 48'(dy_reg);
                mp_reg[r][2] <= 48'($signed(rows[r][47:32])) * 48'(dz_reg);
            end
        end
    end

    // Stage 19: row sums, round half up, saturate, output register.
    logic signed [49:0]         row_sum [3];
    logic signed [49:0]         row_shr [3];
    logic signed [DIR_BITS-1:0] row_sat [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = 50'(mp_reg[r][0]) + 50'(mp_reg[r][1]) + 50'(mp_reg[r][2]);
            row_shr[r] = (row_sum[r] + (50'sd1 <<< (RSH - 1))) >>> RSH;
            if (row_shr[r] > 50'((50'sd1 <<< (DIR_BITS - 1)) - 50'sd1)) begin
                row_sat[r] = {1'b0, {(DIR_BITS-1){1'b1}}};
            end else if (row_shr[r] < -(50'sd1 <<< (DIR_BITS - 1))) begin
                row_sat[r] = {1'b1, {(DIR_BITS-1){1'b0}}};
            end else begin
                row_sat[r] = row_shr[r][DIR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_item.dir_x    <= row_sat[0];
            m_item.dir_y    <= row_sat[1];
            m_item.dir_z    <= row_sat[2];
            m_item.ray_time <= time_pipe_reg[NSTAGE-1];
        end
    end

    // An accepted item occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[1])
        else $error("accepted item missing from first stage");

    // A stalled pipeline keeps every valid bit in place.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && (valid_reg == '0))
        else $error("valid bits survive reset");

endmodule

// ===== src/lcrd_sincos.sv =====
// Pipelined sine and cosine of a turn fraction, signed Q.30 outputs.
// Depends on lcrd_pkg for constants, reciprocals and the context struct.
module lcrd_sincos
    import lcrd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  ce,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic signed [31:0]    sin_q30,
    output logic signed [31:0]    cos_q30
);

    // Quadrant split and reflection into the first octant.
    logic [31:0] v_raw;
    logic [31:0] v_oct;
    logic        swap;
    logic [31:0] v_reg;
    logic [1:0]  quad0_reg;
    logic        swap0_reg;

    assign v_raw = {angle[ANGLE_BITS-3:0], {(34-ANGLE_BITS){1'b0}}};
    assign swap  = (v_raw > 32'h8000_0000);
    assign v_oct = swap ? (32'h0 - v_raw) : v_raw;

    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg     <= v_oct;
            quad0_reg <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
            swap0_reg <= swap;
        end
    end

    // Angle in radians, Q0.32.
    logic [62:0] x_prod;
    logic [31:0] x_reg;
    logic [1:0]  quad1_reg;
    logic        swap1_reg;

    assign x_prod = 63'(v_reg) * 63'(HALF_PI_Q30);

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg     <= x_prod[61:30];
            quad1_reg <= quad0_reg;
            swap1_reg <= swap0_reg;
        end
    end

    // Square of the angle starts both chains.
    logic [63:0] x2_prod;
    lcrd_ctx_t   ctx_reg [NSTEP+1];
    lcrd_ctx_t   ctx_mid_reg [NSTEP];
    logic [32:0] tc_reg [NSTEP+1];
    logic [32:0] ts_reg [1:NSTEP];

    assign x2_prod = 64'(x_reg) * 64'(x_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx_reg[0] <= '{x: x_reg, x2: x2_prod[63:32], quad: quad1_reg, swap: swap1_reg};
            tc_reg[0]  <= ONE_Q32;
        end
    end

    // Context travels two stages per Horner step.
    for (genvar k = 0; k < NSTEP; k++) begin : g_ctx
        always_ff @(posedge aclk) begin
            if (ce) begin
                ctx_mid_reg[k] <= ctx_reg[k];
                ctx_reg[k+1]   <= ctx_mid_reg[k];
            end
        end
    end

    // Cosine Horner steps: t = 1 - (x2 * t) / d.
    for (genvar k = 0; k < NSTEP; k++) begin : g_cos
        logic [64:0] p_prod;
        logic [64:0] q_prod;
        logic [31:0] p_mid_reg;

        assign p_prod = 65'(ctx_reg[k].x2) * 65'(tc_reg[k]);
        assign q_prod = 65'(p_mid_reg) * 65'(cos_rcp(k));

        always_ff @(posedge aclk) begin
            if (ce) begin
                p_mid_reg   <= p_prod[63:32];
                tc_reg[k+1] <= ONE_Q32 - 33'(q_prod >> cos_shift(k));
            end
        end
    end

    // Sine Horner steps; the first step of the sine chain is empty.
    always_ff @(posedge aclk) begin
        if (ce) begin
            ts_reg[1] <= ONE_Q32;
        end
    end

    for (genvar k = 1; k < NSTEP; k++) begin : g_sin
        logic [64:0] p_prod;
        logic [64:0] q_prod;
        logic [31:0] p_mid_reg;

        assign p_prod = 65'(ctx_reg[k].x2) * 65'(ts_reg[k]);
        assign q_prod = 65'(p_mid_reg) * 65'(sin_rcp(k));

        always_ff @(posedge aclk) begin
            if (ce) begin
                p_mid_reg   <= p_prod[63:32];
                ts_reg[k+1] <= ONE_Q32 - 33'(q_prod >> sin_shift(k));
            end
        end
    end

    // Sine magnitude and undo of the octant reflection.
    logic [64:0] sn_prod;
    logic [32:0] sn;
    logic [32:0] s_mag_reg;
    logic [32:0] c_mag_reg;
    logic [1:0]  quad_e_reg;

    assign sn_prod = 65'(ctx_reg[NSTEP].x) * 65'(ts_reg[NSTEP]);
    assign sn      = {1'b0, sn_prod[63:32]};

    always_ff @(posedge aclk) begin
        if (ce) begin
            s_mag_reg  <= ctx_reg[NSTEP].swap ? tc_reg[NSTEP] : sn;
            c_mag_reg  <= ctx_reg[NSTEP].swap ? sn : tc_reg[NSTEP];
            quad_e_reg <= ctx_reg[NSTEP].quad;
        end
    end

    // Quadrant signs on the Q.30 magnitudes.
    logic signed [31:0] s_q30;
    logic signed [31:0] c_q30;

    assign s_q30 = $signed({1'b0, s_mag_reg[32:2]});
    assign c_q30 = $signed({1'b0, c_mag_reg[32:2]});

    always_ff @(posedge aclk) begin
        if (ce) begin
            case (quad_e_reg)
                2'd0: begin
                    sin_q30 <= s_q30;
                    cos_q30 <= c_q30;
                end
                2'd1: begin
                    sin_q30 <= c_q30;
                    cos_q30 <= -s_q30;
                end
                2'd2: begin
                    sin_q30 <= -s_q30;
                    cos_q30 <= -c_q30;
                end
                default: begin
                    sin_q30 <= -c_q30;
                    cos_q30 <= s_q30;
                end
            endcase
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the lat-long camera ray direction block.
// Depends on lcrd_pkg and latlong_camera_ray_direction_top. It predicts every
// result in SystemVerilog and compares it field by field with what the block returns.
module testbench;
    import lcrd_pkg::*;

    localparam int REG_UNUSED = 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
    localparam logic [63:0] HALF_PI = 64'h6487_ED51;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    lcrd_in_t    s_item;
    logic        m_valid;
    logic        m_ready;
    lcrd_out_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Shadow copy of the camera registers.
    logic [31:0] cam_x_scale;
    logic [31:0] cam_y_scale;
    logic [47:0] cam_row [3];
    logic [31:0] cam_open;
    logic [31:0] cam_close;

    lcrd_out_t   expected_rays [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          quiet_cycles;

    latlong_camera_ray_direction_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock with a period of 20.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Sine and cosine within an eighth of a turn, both in Q0.32.
    function automatic void octant_sincos(input logic [63:0] v,
                                          output logic [63:0] sn, output logic [63:0] cs);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (v * HALF_PI) >> 30;
        x2 = (x * x) >> 32;
        t = Q32_ONE;
        t = Q32_ONE - ((x2 * t) >> 32) / 72;
        t = Q32_ONE - ((x2 * t) >> 32) / 42;
        t = Q32_ONE - ((x2 * t) >> 32) / 20;
        t = Q32_ONE - ((x2 * t) >> 32) / 6;
        sn = (x * t) >> 32;
        t = Q32_ONE;
        t = Q32_ONE - ((x2 * t) >> 32) / 90;
        t = Q32_ONE - ((x2 * t) >> 32) / 56;
        t = Q32_ONE - ((x2 * t) >> 32) / 30;
        t = Q32_ONE - ((x2 * t) >> 32) / 12;
        t = Q32_ONE - ((x2 * t) >> 32) / 2;
        cs = t;
    endfunction

    // Signed Q.30 sine and cosine of a Q0.32 turn fraction.
    function automatic void turn_sincos(input logic [63:0] turn,
                                        output longint sn, output longint cs);
        logic [15:0] frac;
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] b;
        longint s;
        longint c;
        frac = turn[31:16];
        v = 64'(frac[13:0]) << 18;
        if (v > (64'd1 << 31)) begin
            octant_sincos(Q32_ONE - v, b, a);
        end else begin
            octant_sincos(v, a, b);
        end
        s = longint'(a >> 2);
        c = longint'(b >> 2);
        case (frac[15:14])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    // One row of the rotation, rounded half up and saturated to Q1.14.
    function automatic logic [15:0] rotate_row(input logic [47:0] row,
                                               input longint dx, input longint dy,
                                               input longint dz);
        longint acc;
        acc = longint'($signed(row[15:0])) * dx + longint'($signed(row[31:16])) * dy
            + longint'($signed(row[47:32])) * dz;
        acc = (acc + (longint'(1) <<< 29)) >>> 30;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc[15:0];
    endfunction

    // Expected ray for one image sample under the current registers.
    function automatic lcrd_out_t predict_ray(input lcrd_in_t smp);
        lcrd_out_t r;
        logic [63:0] phi_turn;
        logic [63:0] theta_turn;
        longint st, ct, sp, cp, dx, dy, dz, t_open, diff, tm;
        phi_turn   = (64'(smp.image_x) * 64'(cam_x_scale)) >> 8;
        theta_turn = (64'(smp.image_y) * 64'(cam_y_scale)) >> 9;
        turn_sincos(theta_turn, st, ct);
        turn_sincos(phi_turn, sp, cp);
        dx = (st * cp) >>> 30;
        dy = ct;
        dz = (st * sp) >>> 30;
        r.dir_x = rotate_row(cam_row[0], dx, dy, dz);
        r.dir_y = rotate_row(cam_row[1], dx, dy, dz);
        r.dir_z = rotate_row(cam_row[2], dx, dy, dz);
        t_open = longint'($signed(cam_open));
        diff = longint'($signed(cam_close)) - t_open;
        tm = t_open + ((diff * longint'(smp.sample_time) + 32768) >>> 16);
        if (tm > 64'sd2147483647) tm = 64'sd2147483647;
        if (tm < -64'sd2147483648) tm = -64'sd2147483648;
        r.ray_time = tm[31:0];
        return r;
    endfunction

    // Offer one item, sometimes after a random gap, and queue its prediction on acceptance.
    task automatic send_sample(input lcrd_in_t smp);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_item = smp;
        do @(posedge aclk); while (!s_ready);
        expected_rays.push_back(predict_ray(smp));
        @(negedge aclk);
    endtask

    task automatic send_xyt(input int x, input int y, input int t);
        lcrd_in_t smp;
        smp.image_x = x[19:0];
        smp.image_y = y[19:0];
        smp.sample_time = t[16:0];
        send_sample(smp);
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty.
    task automatic drain_block();
        s_valid = 1'b0;
        while (expected_rays.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Register write over APB: setup cycle, then access cycle.
    task automatic write_reg(input int idx, input logic [63:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 6'(idx * 8);
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_X_SCALE:    cam_x_scale = value[31:0];
            REG_Y_SCALE:    cam_y_scale = value[31:0];
            REG_ROW_X:      cam_row[0] = value[47:0];
            REG_ROW_Y:      cam_row[1] = value[47:0];
            REG_ROW_Z:      cam_row[2] = value[47:0];
            REG_SHUT_OPEN:  cam_open = value[31:0];
            REG_SHUT_CLOSE: cam_close = value[31:0];
            default: ;
        endcase
    endtask

    function automatic logic [47:0] random_row();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // Random camera setup: sane resolutions half the time, else random or extreme scales.
    task automatic random_camera();
        drain_block();
        case ($urandom_range(3))
            0: begin
                write_reg(REG_X_SCALE, 64'(32'($urandom)));
                write_reg(REG_Y_SCALE, 64'(32'($urandom)));
            end
            1: begin
                write_reg(REG_X_SCALE, 64'hFFFF_FFFF);
                write_reg(REG_Y_SCALE, 64'd0);
            end
            default: begin
                write_reg(REG_X_SCALE, 64'((64'd1 << 32) / $urandom_range(1, 4096)));
                write_reg(REG_Y_SCALE, 64'((64'd1 << 32) / $urandom_range(1, 4096)));
            end
        endcase
        if ($urandom_range(1)) begin
            write_reg(REG_ROW_X, 64'(random_row()));
            write_reg(REG_ROW_Y, 64'(random_row()));
            write_reg(REG_ROW_Z, 64'(random_row()));
        end else begin
            write_reg(REG_ROW_X, 64'h0000_0000_4000);
            write_reg(REG_ROW_Y, 64'h0000_4000_0000);
            write_reg(REG_ROW_Z, 64'h4000_0000_0000);
        end
        write_reg(REG_SHUT_OPEN, 64'(32'($urandom)));
        write_reg(REG_SHUT_CLOSE, 64'(32'($urandom)));
    endtask

    task automatic random_samples(input int count);
        int t;
        repeat (count) begin
            t = ($urandom_range(9) == 0) ? $urandom_range(131071) : $urandom_range(65536);
            if ($urandom_range(3) == 0) begin
                send_xyt($urandom_range(1048575), $urandom_range(1048575), t);
            end else begin
                send_xyt($urandom_range(4095) << 8 | $urandom_range(255),
                         $urandom_range(2047) << 8 | $urandom_range(255), t);
            end
        end
    endtask

    // Edge positions, quadrant boundaries and time extremes, first at reset settings, then at extreme registers.
    task automatic test_directed();
        send_xyt(0, 0, 0);
        send_xyt(1048575, 1048575, 65536);
        send_xyt(1048575, 0, 131071);
        send_xyt(0, 1048575, 1);
        send_xyt(1024 * 256 / 4, 2048 * 256 / 2, 32768);
        send_xyt(1024 * 256 / 2, 2048 * 256 / 4, 65535);
        send_xyt(1024 * 256 * 3 / 4, 2048 * 256 * 3 / 4, 0);
        send_xyt(1024 * 256 / 8, 2048 * 256 / 8, 100);
        send_xyt(1024 * 256 / 8 + 1, 2048 * 256 / 8 + 1, 65537);
        send_xyt(1024 * 256, 2048 * 256, 65536);
        send_xyt(1024 * 256 + 77, 2048 * 256 + 33, 12345);
        send_xyt(20'h55555, 20'hAAAAA, 17'h15555);
        send_xyt(20'hAAAAA, 20'h55555, 17'h0AAAA);
        // Rotation that is not a rotation: coefficient extremes saturate.
        drain_block();
        write_reg(REG_ROW_X, 64'h7FFF_7FFF_7FFF);
        write_reg(REG_ROW_Y, 64'h8000_8000_8000);
        write_reg(REG_ROW_Z, 64'h8000_7FFF_8000);
        write_reg(REG_SHUT_OPEN, 64'h8000_0000);
        write_reg(REG_SHUT_CLOSE, 64'h7FFF_FFFF);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_xyt(1024 * 256 / 8, 2048 * 256 / 4, 131071);
        send_xyt(1024 * 256 * 5 / 8, 2048 * 256 / 3, 0);
        send_xyt(3000, 400000, 65536);
        drain_block();
        write_reg(REG_SHUT_OPEN, 64'h7FFF_FFFF);
        write_reg(REG_SHUT_CLOSE, 64'h8000_0000);
        write_reg(REG_X_SCALE, 64'hFFFF_FFFF);
        write_reg(REG_Y_SCALE, 64'h0);
        send_xyt(1048575, 1048575, 131071);
        send_xyt(12345, 54321, 65536);
        send_xyt(256, 256, 0);
    endtask

    // Random samples under changing cameras, one idling mode at a time.
    task automatic test_random_mode(input int snd_pct, input int rcv_pct, input int count);
        drain_block();
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (count / 60) begin
            random_camera();
            random_samples(60);
        end
    endtask

    // Long receiver stall while items keep coming, so the input backs up.
    task automatic test_backpressure();
        drain_block();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        random_samples(80);
    endtask

    // Receiver: random stalls, or a counted hold-off when requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each returned ray with the oldest prediction.
    always @(posedge aclk) begin
        lcrd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rays.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected ray: got %h", m_item);
            end else begin
                want = expected_rays.pop_front();
                if (m_item.dir_x !== want.dir_x || m_item.dir_y !== want.dir_y
                    || m_item.dir_z !== want.dir_z || m_item.ray_time !== want.ray_time) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ray mismatch: expected dir %h %h %h time %h, got %h %h %h %h",
                                 want.dir_x, want.dir_y, want.dir_z, want.ray_time,
                                 m_item.dir_x, m_item.dir_y, m_item.dir_z, m_item.ray_time);
                end
            end
        end
    end

    // Watchdog on cycles with no item moving and no register access.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn
            || (expected_rays.size() == 0 && !s_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("latlong_camera_ray_direction_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        send_idle_pct = 13;
        recv_idle_pct = 71;
        hold_cycles = 0;
        quiet_cycles = 0;
        cam_x_scale = 32'd1048576;
        cam_y_scale = 32'd2097152;
        cam_row[0] = 48'h0000_0000_4000;
        cam_row[1] = 48'h0000_4000_0000;
        cam_row[2] = 48'h4000_0000_0000;
        cam_open = 32'd0;
        cam_close = 32'd65536;
        // Reset is held low first, then released on a falling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_mode(13, 71, 420);
        test_random_mode(71, 13, 420);
        test_random_mode(0, 0, 420);
        test_backpressure();
        drain_block();

        if (mismatch_count == 0) begin
            $display("latlong_camera_ray_direction_top verification clean");
        end else begin
            $display("latlong_camera_ray_direction_top verification failed");
        end
        $finish;
    end

endmodule
